### rtl/tdpt_pkg.sv
package tdpt_pkg;

  localparam int TDPT_VALUE_WIDTH = 32;

  // program steps of the sequencer
  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_SCREEN   = 3'd1,
    ST_DIV_INIT = 3'd2,
    ST_DIV_STEP = 3'd3,
    ST_TEST_Q   = 3'd4,
    ST_TEST_R   = 3'd5,
    ST_INC      = 3'd6,
    ST_OUT      = 3'd7
  } step_e;

  // how the step counter moves on
  typedef enum logic [1:0] {
    SEQ_NEXT   = 2'd0,
    SEQ_JUMP   = 2'd1,
    SEQ_BRANCH = 2'd2,
    SEQ_WAIT   = 2'd3
  } seq_e;

  typedef enum logic [2:0] {
    COND_ALWAYS   = 3'd0,
    COND_IN_XFER  = 3'd1,
    COND_OUT_XFER = 3'd2,
    COND_SMALL    = 3'd3,
    COND_DIV_LAST = 3'd4,
    COND_D_GT_Q   = 3'd5,
    COND_R_ZERO   = 3'd6
  } cond_e;

  typedef struct packed {
    seq_e  seq;
    cond_e cond;
    step_e target;
    logic  in_ready;
    logic  set_flag;
    logic  flag_val;
    logic  div_init;
    logic  div_step;
    logic  inc_d;
    logic  out_valid;
  } ucode_t;

  function automatic ucode_t ucode_rom(input step_e pc);
    ucode_t cw;
    cw = '0;
    cw.seq    = SEQ_NEXT;
    cw.cond   = COND_ALWAYS;
    cw.target = ST_IDLE;
    unique case (pc)
      ST_IDLE: begin
        cw.seq      = SEQ_WAIT;
        cw.cond     = COND_IN_XFER;
        cw.target   = ST_SCREEN;
        cw.in_ready = 1'b1;
      end
      ST_SCREEN: begin
        cw.seq      = SEQ_BRANCH;
        cw.cond     = COND_SMALL;
        cw.target   = ST_OUT;
        cw.set_flag = 1'b1;
        cw.flag_val = 1'b0;
      end
      ST_DIV_INIT: begin
        cw.div_init = 1'b1;
      end
      ST_DIV_STEP: begin
        cw.seq      = SEQ_WAIT;
        cw.cond     = COND_DIV_LAST;
        cw.target   = ST_TEST_Q;
        cw.div_step = 1'b1;
      end
      ST_TEST_Q: begin
        cw.seq      = SEQ_BRANCH;
        cw.cond     = COND_D_GT_Q;
        cw.target   = ST_OUT;
        cw.set_flag = 1'b1;
        cw.flag_val = 1'b1;
      end
      ST_TEST_R: begin
        cw.seq      = SEQ_BRANCH;
        cw.cond     = COND_R_ZERO;
        cw.target   = ST_OUT;
        cw.set_flag = 1'b1;
        cw.flag_val = 1'b0;
      end
      ST_INC: begin
        cw.seq    = SEQ_JUMP;
        cw.target = ST_DIV_INIT;
        cw.inc_d  = 1'b1;
      end
      ST_OUT: begin
        cw.seq       = SEQ_WAIT;
        cw.cond      = COND_OUT_XFER;
        cw.target    = ST_IDLE;
        cw.out_valid = 1'b1;
      end
    endcase
    return cw;
  endfunction

endpackage

### rtl/trial_division_prime_test.sv
// Trial-division primality test.
// Input stream s_axis carries one signed candidate per transfer in the low
// VALUE_WIDTH bits of tdata. Output stream m_axis returns one transfer per
// candidate with the is_prime flag in tdata bit 0.
// A small microprogram steps a shared restoring divider: for each divisor
// d = 2, 3, ... it forms n / d and n % d one quotient bit per cycle, stops
// with "prime" once d exceeds the quotient and with "not prime" on a zero
// remainder. Values below 2, negatives included, leave after the screen step.
// The time to tvalid grows with the number of trial divisors, which runs up to
// about sqrt(n); the divider loop sets it.
// One candidate is in work at a time: s_axis_tready_o is high only while the
// sequencer sits in its idle step.
// The result is held in a register with tvalid high until m_axis_tready_i
// takes it; a stalled receiver just holds the sequencer in its output step.
// Reset (rst_ni low) returns the sequencer to idle and drops tvalid; no
// clearing pass is needed.
module trial_division_prime_test
  import tdpt_pkg::*;
#(
  parameter int VALUE_WIDTH = TDPT_VALUE_WIDTH,
  localparam int InDataW = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // [VALUE_WIDTH-1:0] candidate, rest zero
  input  logic [InDataW-1:0] s_axis_tdata_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // [0] is_prime, [7:1] zero
  output logic [7:0]         m_axis_tdata_o
);

  localparam int W    = VALUE_WIDTH;
  localparam int CntW = $clog2(W + 1);

  step_e  pc_q, pc_d;
  ucode_t cw;

  logic [W-1:0]    n_q, d_q, rem_q, quo_q;
  logic [CntW-1:0] cnt_q;
  logic            flag_q;

  logic [W:0] shifted, diff;
  logic       no_borrow;
  logic       in_xfer, out_xfer;
  logic       cond, taken;

  assign cw = ucode_rom(pc_q);

  assign s_axis_tready_o = cw.in_ready;
  assign m_axis_tvalid_o = cw.out_valid;
  assign m_axis_tdata_o  = {7'd0, flag_q};

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;

  // one restoring division step: shift in the next dividend bit, try d
  assign shifted   = {rem_q, quo_q[W-1]};
  assign diff      = shifted - {1'b0, d_q};
  assign no_borrow = !diff[W];

  always_comb begin
    unique case (cw.cond)
      COND_ALWAYS:   cond = 1'b1;
      COND_IN_XFER:  cond = in_xfer;
      COND_OUT_XFER: cond = out_xfer;
      COND_SMALL:    cond = n_q[W-1] || (n_q[W-1:1] == '0);
      COND_DIV_LAST: cond = (cnt_q == CntW'(1));
      COND_D_GT_Q:   cond = (d_q > quo_q);
      COND_R_ZERO:   cond = (rem_q == '0);
      default:       cond = 1'b0;
    endcase
  end

  always_comb begin
    unique case (cw.seq)
      SEQ_NEXT: begin
        pc_d  = step_e'(pc_q + 3'd1);
        taken = 1'b0;
      end
      SEQ_JUMP: begin
        pc_d  = cw.target;
        taken = 1'b1;
      end
      SEQ_BRANCH: begin
        pc_d  = cond ? cw.target : step_e'(pc_q + 3'd1);
        taken = cond;
      end
      SEQ_WAIT: begin
        pc_d  = cond ? cw.target : pc_q;
        taken = cond;
      end
      default: begin
        pc_d  = ST_IDLE;
        taken = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw.in_ready && in_xfer) begin
      n_q <= s_axis_tdata_i[W-1:0];
      d_q <= W'(2);
    end
    if (cw.inc_d) begin
      d_q <= d_q + W'(1);
    end
    if (cw.div_init) begin
      rem_q <= '0;
      quo_q <= n_q;
      cnt_q <= CntW'(W);
    end
    if (cw.div_step) begin
      rem_q <= no_borrow ? diff[W-1:0] : shifted[W-1:0];
      quo_q <= {quo_q[W-2:0], no_borrow};
      cnt_q <= cnt_q - CntW'(1);
    end
    if (cw.set_flag && taken) begin
      flag_q <= cw.flag_val;
    end
  end

  a_no_accept_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input accepted while a result is pending");

  a_ready_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i) |=> s_axis_tready_o)
    else $error("sequencer did not return to idle after result transfer");

  a_divisor_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == ST_DIV_STEP) |-> (d_q >= W'(2)))
    else $error("trial divisor below two");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == ST_TEST_Q) |-> (rem_q < d_q))
    else $error("divider remainder not below divisor");

endmodule

### verif/tb_trial_division_prime_test.sv
`timescale 1ns / 1ps

module tb_trial_division_prime_test;
  import tdpt_pkg::*;

  localparam int VW = TDPT_VALUE_WIDTH;
  localparam int IN_W = ((VW + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 100;
  // the last stretch of random items runs with no idling on either side
  localparam int CALM_ITEMS = 20;
  // worst case is about 46341 divisors, each a full division, plus stalls
  localparam int STALL_LIMIT = 5_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int NUM_PROBES = 18;

  typedef logic signed [VW-1:0] cand_t;

  typedef struct packed {
    cand_t candidate;
    logic  known;
    logic  flag;
  } probe_t;

  typedef struct packed {
    cand_t candidate;
    logic  flag;
  } verdict_t;

  // rows with known set carry a typed-in verdict, the rest go to the predictor
  probe_t probes [NUM_PROBES] = '{
    '{32'sh8000_0000, 1'b1, 1'b0},  // most negative
    '{-32'sd1,        1'b1, 1'b0},
    '{32'sd0,         1'b1, 1'b0},
    '{32'sd1,         1'b1, 1'b0},
    '{32'sd2,         1'b1, 1'b1},
    '{32'sd3,         1'b1, 1'b1},
    '{32'sd4,         1'b0, 1'b0},
    '{32'sd5,         1'b0, 1'b0},
    '{32'sd9,         1'b0, 1'b0},
    '{32'sd25,        1'b0, 1'b0},
    '{32'sd49,        1'b0, 1'b0},
    '{32'sd121,       1'b0, 1'b0},
    '{32'sd7919,      1'b0, 1'b0},
    '{32'sd65521,     1'b0, 1'b0},
    '{32'sd65535,     1'b0, 1'b0},
    '{32'sh5555_5555, 1'b0, 1'b0},
    '{32'sh7FFF_FFFE, 1'b0, 1'b0},
    '{32'sh7FFF_FFFF, 1'b0, 1'b0}   // largest positive, longest divisor run
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [IN_W-1:0]   s_axis_tdata_i = '0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [7:0]        m_axis_tdata_o;

  verdict_t          pending_verdicts[$];
  verdict_t          oldest;
  int unsigned       mismatch_count = 0;
  int unsigned       quiet_cycles = 0;
  bit                idle_on = 1'b1;

  trial_division_prime_test #(
    .VALUE_WIDTH(VW)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #6 clk_i = ~clk_i;

  // trial division, divisor against quotient so the bound never overflows
  function automatic logic calc_is_prime(input cand_t cand);
    longint unsigned n;
    longint unsigned d;
    if (cand < 2) return 1'b0;
    n = longint'(cand);
    for (d = 2; d <= n / d; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // mostly cheap candidates: small values, negatives, large multiples of a
  // small prime and values around squares of small numbers
  function automatic cand_t random_candidate();
    int unsigned small_primes [6] = '{2, 3, 5, 7, 11, 13};
    int unsigned pick;
    int unsigned factor;
    int unsigned root;
    pick = $urandom_range(0, 99);
    if (pick < 25) return cand_t'({1'b1, 31'($urandom)});
    if (pick < 50) return cand_t'($urandom_range(0, 1000));
    if (pick < 65) return cand_t'($urandom_range(1001, 65535));
    if (pick < 85) begin
      factor = small_primes[$urandom_range(0, 5)];
      return cand_t'(factor * $urandom_range(2, 32'h7FFF_FFFF / factor));
    end
    root = $urandom_range(2, 250);
    return cand_t'(root * root + $urandom_range(0, 2) - 1);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // tvalid is lowered only ahead of a gap, so back-to-back items keep it high
  task automatic send_candidate(input cand_t cand, input logic known, input logic flag);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IN_W'($unsigned(cand));
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_verdicts.push_back('{cand, known ? flag : calc_is_prime(cand)});
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (probes[i]) begin
      send_candidate(probes[i].candidate, probes[i].known, probes[i].flag);
    end
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
      send_candidate(random_candidate(), 1'b0, 1'b0);
    end
    s_axis_tvalid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // receiver backpressure
  initial begin
    @(posedge clk_i);
    m_axis_tready_i <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("result 0x%02h with nothing expected", m_axis_tdata_o));
      end else begin
        oldest = pending_verdicts.pop_front();
        if (m_axis_tdata_o[0] !== oldest.flag) begin
          report_mismatch($sformatf("candidate %0d: is_prime %b, expected %b",
                                    oldest.candidate, m_axis_tdata_o[0], oldest.flag));
        end
        if (m_axis_tdata_o[7:1] !== 7'b0) begin
          report_mismatch($sformatf("candidate %0d: pad bits 0x%02h not zero",
                                    oldest.candidate, m_axis_tdata_o[7:1]));
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule
